// ----- src/best_fit_normal_quantizer_core_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the best-fit normal quantiser
// Concurrent checks on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_NORMAL_QUANTIZER_CORE_DEFINES_SVH
`define BEST_FIT_NORMAL_QUANTIZER_CORE_DEFINES_SVH

// same-cycle implication
`define BFNQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BFNQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bfnq_pkg.sv -----
// ---------------------------------------------------------------------------
// bfnq_pkg
// Shared widths, constants and types of the best-fit normal quantiser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfnq_pkg;

  localparam int MAX_BITS_DEF = 16;
  localparam int QB_W   = 5;
  localparam logic [QB_W-1:0] QB_RESET = 5'd10;
  localparam int A_W    = 16;   // magnitude of a Q1.14 component
  localparam int V_W    = 33;   // scaled component, 32 fractional bits
  localparam int FRAC   = 32;
  localparam int MA_W   = 33;   // shared multiplier operand widths
  localparam int MB_W   = 32;
  localparam int P_W    = MA_W + MB_W;
  localparam int DOT_W  = 32;
  localparam int D2_W   = 64;
  localparam int LEN_W  = 32;
  localparam int CMP_W  = 96;
  localparam int FIT_W  = 15;
  localparam logic [31:0] OFFSET_Q32 = 32'd2143188680;
  localparam int DEGEN_MAX = 9453568 / 1000;

  // axis codes
  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  // base-point micro steps
  localparam logic [3:0] BS_V0   = 4'd0;
  localparam logic [3:0] BS_V1   = 4'd1;
  localparam logic [3:0] BS_V2   = 4'd2;
  localparam logic [3:0] BS_LAST = 4'd3;

  // candidate micro steps
  localparam logic [3:0] CS_CHECK = 4'd0;
  localparam logic [3:0] CS_DOT1  = 4'd1;
  localparam logic [3:0] CS_DOT2  = 4'd2;
  localparam logic [3:0] CS_DOT3  = 4'd3;
  localparam logic [3:0] CS_LEN1  = 4'd4;
  localparam logic [3:0] CS_LEN2  = 4'd5;
  localparam logic [3:0] CS_LEN3  = 4'd6;
  localparam logic [3:0] CS_SQR   = 4'd7;
  localparam logic [3:0] CS_L_LO  = 4'd8;
  localparam logic [3:0] CS_L_HI  = 4'd9;
  localparam logic [3:0] CS_R_LO  = 4'd10;
  localparam logic [3:0] CS_R_HI  = 4'd11;
  localparam logic [3:0] CS_CMP   = 4'd12;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_BASE,
    S_CAND,
    S_OUT
  } state_t;

  // request to the iterative divider
  typedef struct packed {
    logic           start;
    logic [A_W-1:0] num;
    logic [A_W-1:0] den;
  } div_req_t;

endpackage

// ----- src/bfnq_div.sv -----
// ---------------------------------------------------------------------------
// bfnq_div
// Restoring divider, one quotient bit per cycle: quot = (num << 32) / den,
// valid for num <= den. Pulses done when the quotient is complete.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfnq_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfnq_pkg::div_req_t         req,
  output logic                       done,
  output logic [bfnq_pkg::V_W-1:0]   quot
);
  import bfnq_pkg::*;

  localparam int CNT_W = $clog2(V_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [A_W:0]     rem_r, rem_nxt;
  logic [A_W-1:0]   den_r, den_nxt;
  logic [V_W-1:0]   q_r, q_nxt;
  logic             ge;
  logic [A_W:0]     diff;

  // one restoring step
  always_comb begin
    ge   = rem_r >= {1'b0, den_r};
    diff = ge ? (rem_r - {1'b0, den_r}) : rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (req.start) begin
      rem_nxt = {1'b0, req.num};
      den_nxt = req.den;
      cnt_nxt = CNT_W'(V_W);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = {diff[A_W-1:0], 1'b0};
      q_nxt   = {q_r[V_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- src/bfnq_mul.sv -----
// ---------------------------------------------------------------------------
// bfnq_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfnq_mul (
  input  logic                      clk,
  input  logic [bfnq_pkg::MA_W-1:0] op_a,
  input  logic [bfnq_pkg::MB_W-1:0] op_b,
  output logic [bfnq_pkg::P_W-1:0]  prod
);
  import bfnq_pkg::*;

  logic [P_W-1:0] prod_r;

  // product register, consumed in the cycle after issue
  always_ff @(posedge clk) begin
    prod_r <= P_W'(op_a) * P_W'(op_b);
  end

  assign prod = prod_r;

endmodule

// ----- src/best_fit_normal_quantizer_core.sv -----
// ---------------------------------------------------------------------------
// best_fit_normal_quantizer_core
// Finds the non-negative integer vector in the quantisation cube whose
// direction best matches the absolute value of a Q1.14 normal.
// ---------------------------------------------------------------------------
// Usage:
//  - Input: pulse start with in_normal_x/y/z while busy is low; the
//    transaction is taken at that edge and busy rises on the next cycle.
//  - Output: out_valid is high for exactly one cycle with out_fit_x/y/z and
//    out_degenerate. The receiver cannot stall; it must take it then.
//  - Config: cfg_wr_en/cfg_wr_data write quant_bits (reset 10), only
//    while busy is low; the user must keep to this, the block does not enforce it.
//  - Degenerate normals (largest magnitude <= 0.577) go from idle straight to the output.
//  - Otherwise: three divisions on one restoring divider, then for each
//    scale n from H = 2^(bits-1)-1 down to 1, the base point and then
//    the four corner candidates, one after another, on the one shared
//    multiplier. One transaction at a time.
//  - Reset (rst_n low, synchronous) returns to idle and reloads quant_bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "best_fit_normal_quantizer_core_defines.svh"

module best_fit_normal_quantizer_core #(
  parameter int MAX_BITS = bfnq_pkg::MAX_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [15:0]          in_normal_x,
  input  logic signed [15:0]          in_normal_y,
  input  logic signed [15:0]          in_normal_z,
  output logic                        out_valid,
  output logic [bfnq_pkg::FIT_W-1:0]  out_fit_x,
  output logic [bfnq_pkg::FIT_W-1:0]  out_fit_y,
  output logic [bfnq_pkg::FIT_W-1:0]  out_fit_z,
  output logic                        out_degenerate,
  input  logic                        cfg_wr_en,
  input  logic [bfnq_pkg::QB_W-1:0]   cfg_wr_data
);
  import bfnq_pkg::*;

  localparam int NW = MAX_BITS - 1;  // scale and result width
  localparam int CW = MAX_BITS;      // candidate width (base + 1)

  state_t          state_r, state_nxt;
  logic [3:0]      ustep_r, ustep_nxt;
  logic [1:0]      k_r, k_nxt;
  logic [1:0]      axis_r, axis_nxt;
  logic [1:0]      dom_r, dom_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   half_r, half_nxt;
  logic [A_W-1:0]  a_r [3];
  logic [A_W-1:0]  a_nxt [3];
  logic [V_W-1:0]  v_r [3];
  logic [V_W-1:0]  v_nxt [3];
  logic [CW-1:0]   base_r [3];
  logic [CW-1:0]   base_nxt [3];
  logic [NW-1:0]   best_r [3];
  logic [NW-1:0]   best_nxt [3];
  logic [DOT_W-1:0] acc_r, acc_nxt, dot_r, dot_nxt;
  logic [LEN_W-1:0] len_r, len_nxt, bestlen2_r, bestlen2_nxt;
  logic [D2_W-1:0]  dot2_r, dot2_nxt, bestdot2_r, bestdot2_nxt;
  logic [CMP_W-1:0] lhs_r, lhs_nxt, rhs_r, rhs_nxt;
  logic            have_r, have_nxt;
  logic            deg_r, deg_nxt;
  logic [QB_W-1:0] quant_bits_r;

  logic [A_W-1:0]  abs_in [3];
  logic [1:0]      dom_in;
  logic [A_W-1:0]  amax_in;
  logic            deg_in;
  logic [QB_W-1:0] bits_eff;
  logic [NW-1:0]   half_in;
  logic            accept;
  logic [CW-1:0]   cand [3];
  logic            cand_ok;
  logic            cand_end;
  logic [1:0]      o1, o2;
  logic [P_W-1:0]  prod;
  logic [P_W-1:0]  bsum;
  logic [MA_W-1:0] mul_a;
  logic [MB_W-1:0] mul_b;
  div_req_t        div_req;
  logic            div_done;
  logic [V_W-1:0]  div_quot;

  // shared units
  bfnq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  bfnq_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_bits_r <= QB_RESET;
    end else if (cfg_wr_en) begin
      quant_bits_r <= cfg_wr_data;
    end
  end

  // input magnitudes, dominant axis, degenerate test, cube half size
  always_comb begin
    abs_in[0] = in_normal_x[15] ? (~in_normal_x + 16'd1) : in_normal_x;
    abs_in[1] = in_normal_y[15] ? (~in_normal_y + 16'd1) : in_normal_y;
    abs_in[2] = in_normal_z[15] ? (~in_normal_z + 16'd1) : in_normal_z;
    if (abs_in[0] > abs_in[1]) begin
      dom_in  = AX_X;
      amax_in = abs_in[0];
    end else begin
      dom_in  = AX_Y;
      amax_in = abs_in[1];
    end
    if (abs_in[2] > amax_in) begin
      dom_in  = AX_Z;
      amax_in = abs_in[2];
    end
    deg_in = amax_in <= A_W'(DEGEN_MAX);
    if (quant_bits_r < QB_W'(2)) begin
      bits_eff = QB_W'(2);
    end else if (quant_bits_r > QB_W'(MAX_BITS)) begin
      bits_eff = QB_W'(MAX_BITS);
    end else begin
      bits_eff = quant_bits_r;
    end
    half_in = NW'((CW'(1) << (bits_eff - QB_W'(1))) - CW'(1));
  end

  assign accept = start && (state_r == S_IDLE);

  // corner candidate for the current k
  always_comb begin
    o1 = (dom_r == AX_X) ? AX_Y : AX_X;
    o2 = (dom_r == AX_Z) ? AX_Y : AX_Z;
    for (int i = 0; i < 3; i++) begin
      cand[i] = base_r[i]
              + CW'(k_r[0] && (o1 == 2'(i)))
              + CW'(k_r[1] && (o2 == 2'(i)));
    end
    cand_ok = (cand[0] <= CW'(half_r)) && (cand[1] <= CW'(half_r))
           && (cand[2] <= CW'(half_r));
    cand_end = ((ustep_r == CS_CHECK) && !cand_ok)
            || ((ustep_r == CS_SQR) && !have_r)
            || (ustep_r == CS_CMP);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = deg_in ? S_OUT : S_DIV_GO;
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (div_done) state_nxt = (axis_r == AX_Z) ? S_BASE : S_DIV_GO;
      end
      S_BASE: begin
        if (ustep_r == BS_LAST) state_nxt = S_CAND;
      end
      S_CAND: begin
        if (cand_end && (k_r == 2'd3)) begin
          state_nxt = (n_r == NW'(1)) ? S_OUT : S_BASE;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // unit operands and port outputs
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_BASE: begin
        case (ustep_r)
          BS_V0: begin mul_a = v_r[0]; mul_b = MB_W'(n_r); end
          BS_V1: begin mul_a = v_r[1]; mul_b = MB_W'(n_r); end
          BS_V2: begin mul_a = v_r[2]; mul_b = MB_W'(n_r); end
          default: ;
        endcase
      end
      S_CAND: begin
        case (ustep_r)
          CS_CHECK: begin mul_a = MA_W'(cand[0]); mul_b = MB_W'(a_r[0]); end
          CS_DOT1:  begin mul_a = MA_W'(cand[1]); mul_b = MB_W'(a_r[1]); end
          CS_DOT2:  begin mul_a = MA_W'(cand[2]); mul_b = MB_W'(a_r[2]); end
          CS_DOT3:  begin mul_a = MA_W'(cand[0]); mul_b = MB_W'(cand[0]); end
          CS_LEN1:  begin mul_a = MA_W'(cand[1]); mul_b = MB_W'(cand[1]); end
          CS_LEN2:  begin mul_a = MA_W'(cand[2]); mul_b = MB_W'(cand[2]); end
          CS_LEN3:  begin mul_a = MA_W'(dot_r);   mul_b = MB_W'(dot_r);   end
          CS_SQR:   begin mul_a = MA_W'(prod[31:0]);       mul_b = bestlen2_r; end
          CS_L_LO:  begin mul_a = MA_W'(dot2_r[63:32]);    mul_b = bestlen2_r; end
          CS_L_HI:  begin mul_a = MA_W'(bestdot2_r[31:0]); mul_b = len_r;      end
          CS_R_LO:  begin mul_a = MA_W'(bestdot2_r[63:32]); mul_b = len_r;     end
          default: ;
        endcase
      end
      default: ;
    endcase
    div_req.start = (state_r == S_DIV_GO);
    div_req.num   = a_r[axis_r];
    div_req.den   = a_r[dom_r];
    busy           = (state_r != S_IDLE);
    out_valid      = (state_r == S_OUT);
    out_fit_x      = FIT_W'(best_r[0]);
    out_fit_y      = FIT_W'(best_r[1]);
    out_fit_z      = FIT_W'(best_r[2]);
    out_degenerate = deg_r;
  end

  // datapath sequencing
  always_comb begin
    ustep_nxt    = '0;
    k_nxt        = k_r;
    axis_nxt     = axis_r;
    dom_nxt      = dom_r;
    n_nxt        = n_r;
    half_nxt     = half_r;
    acc_nxt      = acc_r;
    dot_nxt      = dot_r;
    len_nxt      = len_r;
    dot2_nxt     = dot2_r;
    lhs_nxt      = lhs_r;
    rhs_nxt      = rhs_r;
    bestdot2_nxt = bestdot2_r;
    bestlen2_nxt = bestlen2_r;
    have_nxt     = have_r;
    deg_nxt      = deg_r;
    for (int i = 0; i < 3; i++) begin
      a_nxt[i]    = a_r[i];
      v_nxt[i]    = v_r[i];
      base_nxt[i] = base_r[i];
      best_nxt[i] = best_r[i];
    end
    bsum = prod;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            a_nxt[i]    = abs_in[i];
            best_nxt[i] = '0;
          end
          dom_nxt  = dom_in;
          deg_nxt  = deg_in;
          half_nxt = half_in;
          n_nxt    = half_in;
          have_nxt = 1'b0;
          axis_nxt = AX_X;
          k_nxt    = '0;
        end
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          v_nxt[axis_r] = div_quot;
          axis_nxt      = axis_r + 2'd1;
        end
      end
      S_BASE: begin
        ustep_nxt = ustep_r + 4'd1;
        // floor of v*n plus offset on the dominant axis
        case (ustep_r)
          BS_V1: begin
            bsum = prod + ((dom_r == AX_X) ? P_W'(OFFSET_Q32) : '0);
            base_nxt[0] = CW'(bsum[FRAC +: NW]);
          end
          BS_V2: begin
            bsum = prod + ((dom_r == AX_Y) ? P_W'(OFFSET_Q32) : '0);
            base_nxt[1] = CW'(bsum[FRAC +: NW]);
          end
          BS_LAST: begin
            bsum = prod + ((dom_r == AX_Z) ? P_W'(OFFSET_Q32) : '0);
            base_nxt[2] = CW'(bsum[FRAC +: NW]);
            ustep_nxt   = '0;
            k_nxt       = '0;
          end
          default: ;
        endcase
      end
      S_CAND: begin
        ustep_nxt = ustep_r + 4'd1;
        case (ustep_r)
          CS_DOT1: acc_nxt = DOT_W'(prod);
          CS_DOT2: acc_nxt = acc_r + DOT_W'(prod);
          CS_DOT3: dot_nxt = acc_r + DOT_W'(prod);
          CS_LEN1: len_nxt = LEN_W'(prod);
          CS_LEN2: len_nxt = len_r + LEN_W'(prod);
          CS_LEN3: len_nxt = len_r + LEN_W'(prod);
          CS_SQR: begin
            dot2_nxt = D2_W'(prod);
            if (!have_r) begin
              have_nxt     = 1'b1;
              bestdot2_nxt = D2_W'(prod);
              bestlen2_nxt = len_r;
              for (int i = 0; i < 3; i++) best_nxt[i] = NW'(cand[i]);
            end
          end
          CS_L_LO: lhs_nxt = CMP_W'(prod);
          CS_L_HI: lhs_nxt = lhs_r + (CMP_W'(prod) << FRAC);
          CS_R_LO: rhs_nxt = CMP_W'(prod);
          CS_R_HI: rhs_nxt = rhs_r + (CMP_W'(prod) << FRAC);
          CS_CMP: begin
            // strictly higher cosine replaces the best so far
            if (lhs_r > rhs_r) begin
              bestdot2_nxt = dot2_r;
              bestlen2_nxt = len_r;
              for (int i = 0; i < 3; i++) best_nxt[i] = NW'(cand[i]);
            end
          end
          default: ;
        endcase
        if (cand_end) begin
          ustep_nxt = '0;
          k_nxt     = k_r + 2'd1;
          if (k_r == 2'd3) n_nxt = n_r - NW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ustep_r <= '0;
      k_r     <= '0;
      axis_r  <= '0;
      have_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ustep_r <= ustep_nxt;
      k_r     <= k_nxt;
      axis_r  <= axis_nxt;
      have_r  <= have_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dom_r      <= dom_nxt;
    n_r        <= n_nxt;
    half_r     <= half_nxt;
    acc_r      <= acc_nxt;
    dot_r      <= dot_nxt;
    len_r      <= len_nxt;
    dot2_r     <= dot2_nxt;
    lhs_r      <= lhs_nxt;
    rhs_r      <= rhs_nxt;
    bestdot2_r <= bestdot2_nxt;
    bestlen2_r <= bestlen2_nxt;
    deg_r      <= deg_nxt;
    for (int i = 0; i < 3; i++) begin
      a_r[i]    <= a_nxt[i];
      v_r[i]    <= v_nxt[i];
      base_r[i] <= base_nxt[i];
      best_r[i] <= best_nxt[i];
    end
  end

  // checks
  `BFNQ_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy did not rise after accept")
  `BFNQ_ASSERT_NXT(a_out_idle, out_valid, !busy, "not idle after result")
  `BFNQ_ASSERT_IMP(a_deg_zero, out_valid && out_degenerate, (out_fit_x == '0) && (out_fit_y == '0) && (out_fit_z == '0), "degenerate result not zero")
  `BFNQ_ASSERT_IMP(a_fit_cube, out_valid && !out_degenerate, (out_fit_x <= FIT_W'(half_r)) && (out_fit_y <= FIT_W'(half_r)) && (out_fit_z <= FIT_W'(half_r)), "result outside cube")

endmodule
